### rtl/poly_pkg.sv
// Shared types and constants for the Poly1305 authenticator core.
package poly_pkg;

   localparam int BLK_W   = 129;
   localparam int ACC_W   = 130;
   localparam int SUM_W   = 131;
   localparam int LIMB_W  = 26;
   localparam int HLIMB_W = 27;
   localparam int MLT_W   = 29;
   localparam int PROD_W  = 56;
   localparam int DSUM_W  = 59;
   localparam int T_W     = 166;
   localparam int NLIMB   = 5;

   localparam logic [127:0] R_CLAMP = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

   localparam logic [1:0] CSR_R_LOW  = 2'd0;
   localparam logic [1:0] CSR_R_HIGH = 2'd1;
   localparam logic [1:0] CSR_S_LOW  = 2'd2;
   localparam logic [1:0] CSR_S_HIGH = 2'd3;

   typedef struct packed {
      logic [BLK_W-1:0] value;
      logic             last;
   } item_type;

   typedef struct packed {
      logic [127:0] r;
      logic [127:0] s;
   } key_type;

endpackage

### rtl/poly_front.sv
// Front end: masks the message bytes and appends the pad bit.
module poly_front
   import poly_pkg::*;
(
   input  logic [63:0] block_low,
   input  logic [63:0] block_high,
   input  logic [4:0]  byte_count,
   input  logic        last_block,
   output item_type    item
);

   logic [4:0]       count;
   logic [127:0]     block;
   logic [127:0]     masked;
   logic [BLK_W-1:0] pad;

   always_comb begin
      count = byte_count[4] ? 5'd16 : byte_count;
      block = {block_high, block_low};
      for (int i = 0; i < 16; i++) begin
         masked[i*8 +: 8] = (5'(i) < count) ? block[i*8 +: 8] : 8'd0;
      end
      pad = BLK_W'(1) << {count, 3'b000};
      item.value = {1'b0, masked} | pad;
      item.last  = last_block;
   end

endmodule

### rtl/poly_fifo.sv
// Two-entry queue between the front end and the arithmetic back end.
module poly_fifo
   import poly_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  item_type wr_item,
   output logic     rd_valid,
   input  logic     rd_ready,
   output item_type rd_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_item  = entry_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

### rtl/poly_back.sv
// Back end: accumulates, multiplies by r modulo 2^130-5 and produces the tag.
module poly_back
   import poly_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  key_type      key,
   input  logic         q_valid,
   output logic         q_ready,
   input  item_type     q_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [127:0] rsp_tag
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_RED1 = 3'd2;
   localparam logic [2:0] ST_RED2 = 3'd3;
   localparam logic [2:0] ST_RED3 = 3'd4;

   logic [2:0]         state_ff;
   logic [2:0]         cnt_ff;
   logic [ACC_W-1:0]   accum_ff;
   logic [SUM_W-1:0]   h_ff;
   logic               last_ff;
   logic [PROD_W-1:0]  prod_ff [NLIMB];
   logic [DSUM_W-1:0]  dsum_ff;
   logic [T_W-1:0]     t_ff;
   logic [SUM_W-1:0]   t1_ff;
   logic [SUM_W-1:0]   t2_ff;
   logic               out_valid_ff;
   logic [127:0]       tag_ff;

   logic [127:0]       rc;
   logic [LIMB_W-1:0]  rl [NLIMB];
   logic [MLT_W-1:0]   m5 [NLIMB];
   logic [HLIMB_W-1:0] hl [NLIMB];
   logic [MLT_W-1:0]   mult [NLIMB];
   logic [DSUM_W-1:0]  dsum_in;
   logic [2:0]         row;
   logic [6:0]         shamt;
   logic [35:0]        t_hi;
   logic [SUM_W-1:0]   g;
   logic [ACC_W-1:0]   res;
   logic               out_free;
   int                 idx;

   always_comb begin
      rc = key.r & R_CLAMP;
      for (int k = 0; k < NLIMB - 1; k++) begin
         rl[k] = rc[k*LIMB_W +: LIMB_W];
         hl[k] = {1'b0, h_ff[k*LIMB_W +: LIMB_W]};
      end
      rl[4] = {2'b00, rc[127:104]};
      hl[4] = h_ff[SUM_W-1:104];
      for (int k = 0; k < NLIMB; k++) begin
         m5[k] = {1'b0, rl[k], 2'b00} + MLT_W'(rl[k]);
      end
      for (int j = 0; j < NLIMB; j++) begin
         idx = int'(cnt_ff) - j;
         if (cnt_ff > 3'd4) begin
            mult[j] = '0;
         end else if (idx >= 0) begin
            mult[j] = MLT_W'(rl[3'(idx)]);
         end else begin
            mult[j] = m5[3'(idx + NLIMB)];
         end
      end
      dsum_in = '0;
      for (int j = 0; j < NLIMB; j++) begin
         dsum_in = dsum_in + DSUM_W'(prod_ff[j]);
      end
      row   = cnt_ff - 3'd2;
      shamt = 7'(row) * 7'd26;
      t_hi  = t_ff[T_W-1:ACC_W];
      g     = t2_ff + SUM_W'(5);
      res   = g[ACC_W] ? g[ACC_W-1:0] : t2_ff[ACC_W-1:0];
      out_free = !out_valid_ff || rsp_ready;
   end

   assign q_ready   = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_tag   = tag_ff;

   always_ff @(posedge clock) begin
      for (int j = 0; j < NLIMB; j++) begin
         prod_ff[j] <= PROD_W'(hl[j]) * PROD_W'(mult[j]);
      end
      dsum_ff <= dsum_in;
      t1_ff   <= SUM_W'(t_ff[ACC_W-1:0]) + SUM_W'({t_hi, 2'b00}) + SUM_W'(t_hi);
      t2_ff   <= SUM_W'(t1_ff[ACC_W-1:0]) + (t1_ff[ACC_W] ? SUM_W'(5) : '0);
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 3'd0;
         accum_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready && !(state_ff == ST_RED3 && last_ff)) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  h_ff     <= SUM_W'(accum_ff) + SUM_W'(q_item.value);
                  last_ff  <= q_item.last;
                  t_ff     <= '0;
                  cnt_ff   <= 3'd0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (cnt_ff >= 3'd2) t_ff <= t_ff + (T_W'(dsum_ff) << shamt);
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd6) state_ff <= ST_RED1;
            end
            ST_RED1: state_ff <= ST_RED2;
            ST_RED2: state_ff <= ST_RED3;
            ST_RED3: begin
               if (!last_ff) begin
                  accum_ff <= res;
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  tag_ff       <= res[127:0] + key.s;
                  out_valid_ff <= 1'b1;
                  accum_ff     <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### rtl/poly1305_mac_core.sv
// Top level of the Poly1305 one-time authenticator core.
// Each transfer on the request channel carries one message block of up to sixteen bytes, and the
// transfer that has tlast set closes the message and yields one 128-bit tag on the response
// channel. In the arithmetic back end a block is first added into the accumulator, then its five
// product rows run through the five-lane multiplier array and its adder, and last come the
// reduction modulo 2^130-5 and, for the closing block, the final add of s. A two-entry queue
// lets up to two further blocks be taken while one is in work. The user must write key registers
// through the csr port only while no message is in progress; the block itself does not enforce this.
module poly1305_mac_core
   import poly_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // block_low, block_high, byte_count, zero fill
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // tag_low, tag_high
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [63:0]  csr_wdata
);

   logic [63:0] r_low_ff;
   logic [63:0] r_high_ff;
   logic [63:0] s_low_ff;
   logic [63:0] s_high_ff;
   key_type     key;
   item_type    front_item;
   item_type    q_item;
   logic        q_valid;
   logic        q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_low_ff  <= '0;
         r_high_ff <= '0;
         s_low_ff  <= '0;
         s_high_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_R_LOW:  r_low_ff  <= csr_wdata;
            CSR_R_HIGH: r_high_ff <= csr_wdata;
            CSR_S_LOW:  s_low_ff  <= csr_wdata;
            CSR_S_HIGH: s_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign key.r = {r_high_ff, r_low_ff};
   assign key.s = {s_high_ff, s_low_ff};

   poly_front u_front (
      .block_low  (req_tdata[63:0]),
      .block_high (req_tdata[127:64]),
      .byte_count (req_tdata[132:128]),
      .last_block (req_tlast),
      .item       (front_item)
   );

   poly_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_ready (req_tready),
      .wr_item  (front_item),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_item  (q_item)
   );

   poly_back u_back (
      .clock     (clock),
      .reset     (reset),
      .key       (key),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_tag   (rsp_tdata)
   );

endmodule

### rtl/poly_checker.sv
// Port-level checks for the Poly1305 core and their binding to the top level.
module poly_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response withdrawn before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response present straight after reset");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready && req_tlast))
      else $error("tag appeared one cycle after the closing block");

endmodule

bind poly1305_mac_core poly_checker u_poly_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### dv/testbench.sv
// Self-checking testbench for the Poly1305 core: directed and random messages against a model.
`timescale 1ns / 1ps

module testbench
   import poly_pkg::*;
();

   typedef struct {
      logic [63:0] blk_lo;
      logic [63:0] blk_hi;
      logic [4:0]  count;
      logic        last;
   } block_item;

   typedef struct {
      logic [63:0] tag_lo;
      logic [63:0] tag_hi;
   } tag_item;

   localparam logic [129:0] PRIME = {130{1'b1}} - 130'd4;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_addr = CSR_R_LOW;
   logic [63:0]  csr_wdata = '0;

   block_item    pending_blocks[$];
   tag_item      expected_tags[$];
   logic [127:0] key_r = '0;
   logic [127:0] key_s = '0;
   logic [129:0] accum = '0;
   int           mismatches = 0;
   int           send_idle = 0;
   int           recv_idle = 0;
   int           recv_hold = 0;
   bit           quiet = 1'b0;

   poly1305_mac_core DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [129:0] mul_mod(logic [129:0] a, logic [127:0] r);
      logic [259:0] prod;
      prod = a * r;
      return prod % PRIME;
   endfunction

   // Folds one block into the accumulator and returns whether a tag results.
   function automatic bit absorb_block(block_item b, output tag_item t);
      int          n;
      logic [127:0] msg;
      logic [130:0] sum;
      logic [127:0] tag;
      n = (b.count > 16) ? 16 : b.count;
      msg = {b.blk_hi, b.blk_lo};
      if (n < 16) msg &= (128'd1 << (8 * n)) - 1;
      sum = accum + msg + (131'd1 << (8 * n));
      accum = mul_mod(130'(sum % PRIME), key_r & R_CLAMP);
      t = '{default: '0};
      if (!b.last) return 0;
      tag = accum[127:0] + key_s;
      t.tag_lo = tag[63:0];
      t.tag_hi = tag[127:64];
      accum = '0;
      return 1;
   endfunction

   always @(posedge clock) begin
      tag_item t;
      if (!reset && req_tvalid && req_tready) begin
         if (absorb_block(pending_blocks.pop_front(), t)) expected_tags.push_back(t);
      end
      if (!reset && (!req_tvalid || req_tready)) begin
         if (pending_blocks.size() > 0 && (quiet || send_idle == 0)) begin
            block_item b;
            b = pending_blocks[0];
            req_tvalid <= 1'b1;
            req_tdata <= {3'b0, b.count, b.blk_hi, b.blk_lo};
            req_tlast <= b.last;
            if (!quiet && $urandom_range(0, 9) == 0) send_idle = $urandom_range(1, 4);
         end else begin
            req_tvalid <= 1'b0;
            if (send_idle > 0) send_idle--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tags.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected tag %h", rsp_tdata);
         end else begin
            tag_item e;
            e = expected_tags.pop_front();
            if (rsp_tdata !== {e.tag_hi, e.tag_lo}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tag mismatch: expected %h_%h got %h", e.tag_hi, e.tag_lo, rsp_tdata);
            end
         end
      end
      if (recv_hold > 0) begin
         recv_hold--;
         rsp_tready <= 1'b0;
      end else if (!quiet && recv_idle > 0) begin
         recv_idle--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) recv_idle = $urandom_range(1, 4);
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_R_LOW:  key_r[63:0] = val;
         CSR_R_HIGH: key_r[127:64] = val;
         CSR_S_LOW:  key_s[63:0] = val;
         default:    key_s[127:64] = val;
      endcase
   endtask

   task automatic drain();
      while (pending_blocks.size() > 0 || expected_tags.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic add_block(logic [63:0] lo, logic [63:0] hi, logic [4:0] n, logic l);
      pending_blocks.push_back('{lo, hi, n, l});
   endtask

   task automatic add_message(int nblocks);
      for (int i = 0; i < nblocks; i++) begin
         logic [4:0] n;
         n = (i == nblocks - 1) ? 5'($urandom_range(0, 31)) :
             ($urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 31)) : 5'd16);
         add_block(rand64(), rand64(), n, i == nblocks - 1);
      end
   endtask

   task automatic set_keys(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] d);
      write_reg(CSR_R_LOW, a);
      write_reg(CSR_R_HIGH, b);
      write_reg(CSR_S_LOW, c);
      write_reg(CSR_S_HIGH, d);
   endtask

   initial begin
      int sent;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_keys('1, '1, '1, '1);
      add_block('1, '1, 5'd16, 1'b1);
      add_block('0, '0, 5'd0, 1'b1);
      add_block('1, '1, 5'd31, 1'b0);
      add_block('1, '1, 5'd7, 1'b0);
      add_block('1, '1, 5'd8, 1'b0);
      add_block('1, '1, 5'd15, 1'b1);
      add_block('1, '1, 5'd1, 1'b1);
      drain();
      set_keys('0, '0, '0, '0);
      add_block('1, '1, 5'd16, 1'b1);
      add_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd17, 1'b1);
      drain();
      set_keys(64'h0ffffffc0fffffff, 64'h0ffffffc0ffffffc, '1, '0);
      for (int k = 0; k < 6; k++) add_block('1, '1, 5'd16, k == 5);
      drain();
      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         set_keys(rand64(), rand64(), rand64(), rand64());
         if (phase == 1) recv_hold = 300;
         while (sent < 400 * (phase + 1)) begin
            int nb;
            nb = $urandom_range(1, 6);
            add_message(nb);
            sent += nb;
         end
         drain();
      end
      quiet = 1'b1;
      while (sent < 1750) begin
         add_message(3);
         sent += 3;
      end
      drain();
      if (mismatches == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("testbench failed");
      $finish;
   end

endmodule

### sim.f
rtl/poly_pkg.sv
rtl/poly_front.sv
rtl/poly_fifo.sv
rtl/poly_back.sv
rtl/poly1305_mac_core.sv
rtl/poly_checker.sv
dv/testbench.sv
